// ===== hdl/modulated_feedback_delay_assert.svh =====
// ----------------------------------------------------------------------------
// modulated feedback delay assertion macros
// immediate-antecedent and next-cycle property forms clocked on i_clk,
// disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef MODULATED_FEEDBACK_DELAY_ASSERT_SVH
`define MODULATED_FEEDBACK_DELAY_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define MFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfd_pkg
// sizes, codes, saturation helper and sine table for the modulated delay
// ----------------------------------------------------------------------------
package mfd_pkg;

    localparam int RING_DEPTH = 131072;
    localparam int RING_W     = $clog2(RING_DEPTH);
    localparam int POS_W      = RING_W + 8;
    localparam int SINE_DEPTH = 1024;
    localparam int SINE_W     = $clog2(SINE_DEPTH);
    localparam int PHASE_W    = 24;
    localparam int SAMPLE_W   = 16;
    localparam int NUM_LANES  = 2;
    localparam int PADDR_W    = 5;
    localparam int SAT_W      = 20;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    localparam logic [POS_W-1:0] DELAY_MIN = POS_W'(256);
    localparam logic [POS_W-1:0] DELAY_MAX = POS_W'((RING_DEPTH - 1) * 256);
    localparam logic [15:0]      Q15_ONE   = 16'h8000;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(SAMPLE_MAX);
    localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(SAMPLE_MIN);

    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

    typedef logic [RING_W-1:0]          t_ring_idx;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef t_sample                    t_sine_rom [SINE_DEPTH];

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_DLY,
        S_POS,
        S_RD0,
        S_RD1,
        S_INT,
        S_FB,
        S_MIX
    } t_state;

    typedef enum logic [2:0] {
        REG_BYPASS    = 3'd0,
        REG_DELAY     = 3'd1,
        REG_FEEDBACK  = 3'd2,
        REG_MIX       = 3'd3,
        REG_LFO_STEP  = 3'd4,
        REG_LFO_DEPTH = 3'd5
    } t_reg_idx;

    function automatic t_sample sat16(input logic signed [SAT_W-1:0] v);
        t_sample res;
        if (v > SAT_HI) begin
            res = t_sample'(SAMPLE_MAX);
        end else if (v < SAT_LO) begin
            res = t_sample'(SAMPLE_MIN);
        end else begin
            res = v[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    // q30 angle, taylor series to x^13, rounded half up
    function automatic t_sample sine_entry(input int unsigned idx);
        logic [63:0]        a;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        logic               neg;
        t_sample            mag;
        a   = (64'(idx) * TWO_PI_Q30) / 64'(SINE_DEPTH);
        neg = 1'b0;
        if (a >= PI_Q30) begin
            a   = a - PI_Q30;
            neg = 1'b1;
        end
        if (a > HALF_PI_Q30) begin
            a = PI_Q30 - a;
        end
        x2   = (a * a) >> 30;
        term = a;
        sum  = $signed(a);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0) begin
            sum = 0;
        end
        v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        mag = $signed(v[SAMPLE_W-1:0]);
        return neg ? -mag : mag;
    endfunction

    function automatic t_sine_rom make_sine_rom();
        t_sine_rom rom;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = make_sine_rom();

endpackage

// ===== hdl/modulated_feedback_delay.sv =====
// ----------------------------------------------------------------------------
// modulated_feedback_delay
// stereo q1.15 delay line with sine lfo modulation, feedback and dry/wet mix
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall carry one left/right sample pair per
//   transfer. output channel: o_out_valid / i_out_stall carry one mixed pair
//   per input transfer, in order. registers sit on an apb-style port at byte
//   addresses 4*i; writes belong in idle periods only.
// sequence
//   one pair at a time: the steps are lfo multiply, delay multiply,
//   clamp, address, two reads of the single ring memory port, interpolation,
//   feedback write-back and mix. the result shows on o_out_valid once the mix
//   step has stored it. in bypass a pair goes straight to the mix step.
//   the next pair is taken while the previous result waits in the output
//   register; the mix step holds only if that register is still full.
// reset
//   synchronous, active low. registers take their reset values, the write
//   index and lfo phase clear. the ring needs no clearing pass: an entry not
//   written since reset (index at or past the write index before the first
//   wrap) reads as zero, so the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module modulated_feedback_delay import mfd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // sample input
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [15:0]  i_left_in,
    input  logic signed [15:0]  i_right_in,
    // sample output
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [15:0]  o_left_out,
    output logic signed [15:0]  o_right_out
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic        r_bypass;
    logic [16:0] r_delay_base;
    logic [14:0] r_feedback_gain;
    logic [15:0] r_mix_level;
    logic [19:0] r_lfo_step;
    logic [15:0] r_lfo_depth;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass        <= 1'b0;
            r_delay_base    <= 17'd12000;
            r_feedback_gain <= '0;
            r_mix_level     <= 16'd16384;
            r_lfo_step      <= '0;
            r_lfo_depth     <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BYPASS:    r_bypass        <= pwdata[0];
                REG_DELAY:     r_delay_base    <= pwdata[16:0];
                REG_FEEDBACK:  r_feedback_gain <= pwdata[14:0];
                REG_MIX:       r_mix_level     <= pwdata[15:0];
                REG_LFO_STEP:  r_lfo_step      <= pwdata[19:0];
                REG_LFO_DEPTH: r_lfo_depth     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_BYPASS:    prdata = 32'(r_bypass);
            REG_DELAY:     prdata = 32'(r_delay_base);
            REG_FEEDBACK:  prdata = 32'(r_feedback_gain);
            REG_MIX:       prdata = 32'(r_mix_level);
            REG_LFO_STEP:  prdata = 32'(r_lfo_step);
            REG_LFO_DEPTH: prdata = 32'(r_lfo_depth);
            default:       prdata = '0;
        endcase
    end

    // depth and mix above one act as one
    logic [15:0] depth_eff;
    logic [15:0] mix_eff;
    logic        lfo_en;

    assign depth_eff = (r_lfo_depth > Q15_ONE) ? Q15_ONE : r_lfo_depth;
    assign mix_eff   = (r_mix_level > Q15_ONE) ? Q15_ONE : r_mix_level;
    assign lfo_en    = (r_lfo_step != '0) && (r_lfo_depth != '0);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    t_state    r_state;
    t_state    n_state;
    logic      in_acc;
    logic      out_free;
    logic      mem_we;
    t_ring_idx rd_addr;
    t_ring_idx r_i0;
    t_ring_idx i1;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    // output register empty, or its pair leaves this cycle
    assign out_free   = !o_out_valid || !i_out_stall;
    assign i1         = (r_i0 == t_ring_idx'(RING_DEPTH - 1)) ? '0 : r_i0 + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        mem_we  = 1'b0;
        rd_addr = r_i0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = r_bypass ? S_MIX : S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_DLY;
            S_DLY:  n_state = S_POS;
            S_POS:  n_state = S_RD0;
            S_RD0: begin
                rd_addr = r_i0;
                n_state = S_RD1;
            end
            S_RD1: begin
                rd_addr = i1;
                n_state = S_INT;
            end
            S_INT:  n_state = S_FB;
            S_FB: begin
                mem_we  = 1'b1;
                n_state = S_MIX;
            end
            S_MIX: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // lfo: phase register and registered sine table read at transfer
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0] r_phase;
    t_sample            r_sine;
    logic               r_lfo_on;
    logic               r_byp;
    t_sample            r_x [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (in_acc && lfo_en && !r_bypass) begin
            r_phase <= r_phase + PHASE_W'(r_lfo_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x[0]   <= i_left_in;
            r_x[1]   <= i_right_in;
            r_byp    <= r_bypass;
            r_lfo_on <= lfo_en;
            r_sine   <= SINE_ROM[r_phase[PHASE_W-1 -: SINE_W]];
        end
    end

    // ------------------------------------------------------------------
    // delay: base * (1 + lfo * depth) in q8 samples, clamped
    // ------------------------------------------------------------------
    t_sample            lfo_val;
    logic signed [32:0] p1_full;
    logic signed [30:0] r_p1;
    logic signed [48:0] p2_full;
    logic signed [47:0] r_p2;
    logic signed [25:0] dly_off;
    logic signed [26:0] d_raw;
    logic [25:0]        d_mag;
    logic [POS_W-1:0]   r_d;
    logic [POS_W-1:0]   pos;
    logic [7:0]         r_frac;

    assign lfo_val = r_lfo_on ? r_sine : '0;
    assign p1_full = lfo_val * $signed({1'b0, depth_eff});
    assign p2_full = $signed({1'b0, r_delay_base}) * r_p1;
    // floor of the product over 2^22
    assign dly_off = r_p2[47:22];
    assign d_raw   = $signed({2'b00, r_delay_base, 8'h00}) + dly_off;
    assign d_mag   = d_raw[25:0];
    // read position trails the write position, wrapping over the ring
    assign pos     = {r_wi, 8'h00} - r_d;

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_MUL1: r_p1 <= p1_full[30:0];
            S_MUL2: r_p2 <= p2_full[47:0];
            S_DLY: begin
                if (d_raw[26] || (32'(d_mag) < 32'(DELAY_MIN))) begin
                    r_d <= DELAY_MIN;
                end else if (32'(d_mag) > 32'(DELAY_MAX)) begin
                    r_d <= DELAY_MAX;
                end else begin
                    r_d <= POS_W'(d_mag);
                end
            end
            S_POS: begin
                r_i0   <= pos[POS_W-1:8];
                r_frac <= pos[7:0];
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // ring memory, both channels side by side in one word
    // ------------------------------------------------------------------
    logic [2*SAMPLE_W-1:0] r_ring [RING_DEPTH];
    logic [2*SAMPLE_W-1:0] r_q;
    logic [2*SAMPLE_W-1:0] mem_wdata;
    t_ring_idx             r_wi;
    logic                  r_wrap;
    logic                  r_v0;
    logic                  r_v1;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[r_wi] <= mem_wdata;
        end
        r_q <= r_ring[rd_addr];
    end

    // write index plus wrap flag tell which entries hold written data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi   <= '0;
            r_wrap <= 1'b0;
        end else if (mem_we) begin
            if (r_wi == t_ring_idx'(RING_DEPTH - 1)) begin
                r_wi   <= '0;
                r_wrap <= 1'b1;
            end else begin
                r_wi <= r_wi + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // per-channel lanes: interpolation, feedback, mix
    // ------------------------------------------------------------------
    t_sample            r_s0    [NUM_LANES];
    t_sample            r_del   [NUM_LANES];
    t_sample            s1      [NUM_LANES];
    logic signed [16:0] idiff   [NUM_LANES];
    logic signed [25:0] iprod   [NUM_LANES];
    logic signed [26:0] iacc    [NUM_LANES];
    logic signed [31:0] fbp     [NUM_LANES];
    logic signed [31:0] fbs     [NUM_LANES];
    logic signed [17:0] wsum    [NUM_LANES];
    t_sample            wr      [NUM_LANES];
    logic signed [16:0] mdiff   [NUM_LANES];
    logic signed [33:0] mp      [NUM_LANES];
    logic signed [34:0] msum    [NUM_LANES];
    t_sample            mres    [NUM_LANES];

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            s1[l]    = r_v1 ? $signed(r_q[SAMPLE_W*l +: SAMPLE_W]) : '0;
            // s0*(256-frac) + s1*frac rewritten with one product
            idiff[l] = s1[l] - r_s0[l];
            iprod[l] = idiff[l] * $signed({1'b0, r_frac});
            iacc[l]  = $signed({r_s0[l], 8'h00}) + iprod[l] + 27'sd128;
            fbp[l]   = r_del[l] * $signed({1'b0, r_feedback_gain});
            fbs[l]   = fbp[l] + 32'sd16384;
            wsum[l]  = r_x[l] + $signed(fbs[l][31:15]);
            wr[l]    = sat16(SAT_W'(wsum[l]));
            // x*(1-mix) + del*mix rewritten with one product
            mdiff[l] = r_del[l] - r_x[l];
            mp[l]    = mdiff[l] * $signed({1'b0, mix_eff});
            msum[l]  = $signed({r_x[l], 15'h0000}) + mp[l] + 35'sd16384;
            mres[l]  = r_byp ? r_x[l] : sat16(msum[l][34:15]);
        end
    end

    assign mem_wdata = {wr[1], wr[0]};

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_RD0: r_v0 <= r_wrap || (r_i0 < r_wi);
            S_RD1: begin
                r_v1 <= r_wrap || (i1 < r_wi);
                for (int l = 0; l < NUM_LANES; l++) begin
                    r_s0[l] <= r_v0 ? $signed(r_q[SAMPLE_W*l +: SAMPLE_W]) : '0;
                end
            end
            S_INT: begin
                for (int l = 0; l < NUM_LANES; l++) begin
                    r_del[l] <= iacc[l][23:8];
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic    r_ovalid;
    t_sample r_oleft;
    t_sample r_oright;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_MIX) && out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_MIX) && out_free) begin
            r_oleft  <= mres[0];
            r_oright <= mres[1];
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_left_out  = r_oleft;
    assign o_right_out = r_oright;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`include "modulated_feedback_delay_assert.svh"

    `MFD_ASSERT_NEXT(a_wi_step, r_state == S_FB, r_wi == t_ring_idx'($past(r_wi) + 1'b1), "write index did not advance by one after a ring write")
    `MFD_ASSERT_NEXT(a_wrap_sticky, r_wrap, r_wrap, "ring wrap flag cleared outside reset")
    `MFD_ASSERT_NEXT(a_accept_dispatch, in_acc, (r_state == S_MUL1) || (r_state == S_MIX), "transfer did not start the lfo step or the bypass path")
    `MFD_ASSERT_NEXT(a_phase_hold, !in_acc, $stable(r_phase), "lfo phase moved without an input transfer")

endmodule
